/* rtl/core/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SRAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SRAG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/srag_pkg.sv */
// ----------------------------------------------------------------------------
// srag_pkg
// shared types and codes of the strided reshape address generator
// ----------------------------------------------------------------------------
package srag_pkg;
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_MOVE    = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [1:0] SEL_SOURCE = 2'd0;
  localparam logic [1:0] SEL_RESULT = 2'd1;
  localparam logic [1:0] SEL_PAD    = 2'd2;
  localparam logic [1:0] SEL_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic [1:0] PH_SOURCE = 2'd0;
  localparam logic [1:0] PH_PAD    = 2'd1;
  localparam logic [1:0] PH_FIN    = 2'd2;

  localparam logic [1:0] CFG_SOURCE_RANK = 2'd0;
  localparam logic [1:0] CFG_RESULT_RANK = 2'd1;
  localparam logic [1:0] CFG_PAD_RANK    = 2'd2;

  localparam int EXT_W = 31;
  localparam int STR_W = 32;

  // word handed from front to back
  typedef struct packed {
    logic [1:0]       cmd;
    logic [1:0]       sel;
    logic [2:0]       dim;
    logic [EXT_W-1:0] extent;
    logic [STR_W-1:0] stride;
  } srag_word_t;
endpackage

/* rtl/core/srag_if.sv */
// ----------------------------------------------------------------------------
// srag_in_if / srag_out_if / srag_cfg_if
// valid-ready channels of the address generator
// ----------------------------------------------------------------------------
interface srag_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  array_select;
  logic [2:0]  dim_index;
  logic [30:0] extent;
  logic [31:0] stride;
  modport source (output valid, cmd, array_select, dim_index, extent, stride, input ready);
  modport sink (input valid, cmd, array_select, dim_index, extent, stride, output ready);
endinterface

interface srag_out_if #(parameter int ADDR_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic                 move_valid;
  logic [ADDR_BITS-1:0] read_address;
  logic                 from_pad;
  logic [ADDR_BITS-1:0] write_address;
  logic                 last_move;
  logic [1:0]           status;
  modport source (output valid, move_valid, read_address, from_pad, write_address,
                  last_move, status, input ready);
  modport sink (input valid, move_valid, read_address, from_pad, write_address,
                last_move, status, output ready);
endinterface

interface srag_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/srag_fifo.sv */
// ----------------------------------------------------------------------------
// srag_fifo
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module srag_fifo
  import srag_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  srag_word_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output srag_word_t rd_data
);
  srag_word_t mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

/* rtl/core/srag_front.sv */
// ----------------------------------------------------------------------------
// srag_front
// takes input words, squashes unknown commands and bad loads into no-ops
// ----------------------------------------------------------------------------
module srag_front
  import srag_pkg::*;
#(
  parameter int MAX_RANK = 7
) (
  srag_in_if.sink     in_ch,
  output logic        q_valid,
  input  logic        q_ready,
  output srag_word_t  q_data
);
  logic [1:0] cmd_c;

  // a load that cannot land is turned into a no-op
  always_comb begin
    cmd_c = in_ch.cmd;
    case (in_ch.cmd)
      CMD_LOAD, CMD_RESTART, CMD_MOVE: cmd_c = in_ch.cmd;
      default: cmd_c = CMD_NOP;
    endcase
    if (in_ch.cmd == CMD_LOAD &&
        (in_ch.array_select == SEL_NONE || 32'(in_ch.dim_index) >= 32'(MAX_RANK)))
      cmd_c = CMD_NOP;
  end

  assign q_valid       = in_ch.valid;
  assign in_ch.ready   = q_ready;
  assign q_data.cmd    = cmd_c;
  assign q_data.sel    = in_ch.array_select;
  assign q_data.dim    = in_ch.dim_index;
  assign q_data.extent = in_ch.extent;
  assign q_data.stride = in_ch.stride;
endmodule

/* rtl/core/srag_back.sv */
// ----------------------------------------------------------------------------
// srag_back
// descriptor file, three odometers and the registered result stage
// ----------------------------------------------------------------------------
module srag_back
  import srag_pkg::*;
#(
  parameter int MAX_RANK  = 7,
  parameter int ADDR_BITS = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  output logic         q_ready,
  input  srag_word_t   q_data,
  input  logic [2:0]   srank,
  input  logic [2:0]   rrank,
  input  logic [2:0]   prank,
  srag_out_if.source   out_ch
);
  localparam int AW = ADDR_BITS;

  logic [EXT_W-1:0] ext_r [3][MAX_RANK];
  logic [STR_W-1:0] str_r [3][MAX_RANK];
  logic [EXT_W-1:0] cnt_r [3][MAX_RANK];
  logic [AW-1:0]    off_r [3][MAX_RANK];
  logic [1:0]       ph_r, ph_nxt;

  logic [EXT_W-1:0] cnt_nxt [3][MAX_RANK];
  logic [AW-1:0]    off_nxt [3][MAX_RANK];
  logic [AW-1:0]    sum_c [3];
  logic [2:0]       carry;
  logic [2:0]       adv;
  logic [2:0]       zero_any;
  logic [3:0]       rk [3];
  logic             step, o_valid_r;
  logic             mv, fp, lst;
  logic [1:0]       stv;
  logic             restart;

  // effective ranks
  function automatic logic [3:0] eff_rank(input logic [2:0] r, input logic zero_ok);
    logic [3:0] v;
    v = {1'b0, r};
    if (r == 3'd0 && !zero_ok) v = 4'd1;
    if (32'(v) > MAX_RANK) v = 4'(MAX_RANK);
    return v;
  endfunction

  assign rk[0] = eff_rank(srank, 1'b0);
  assign rk[1] = eff_rank(rrank, 1'b0);
  assign rk[2] = eff_rank(prank, 1'b1);

  assign q_ready = !o_valid_r || out_ch.ready;
  assign step    = q_valid && q_ready;
  assign restart = step && q_data.cmd == CMD_RESTART;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      zero_any[a] = 1'b0;
      for (int k = 0; k < MAX_RANK; k++)
        if (32'(k) < 32'(rk[a]) && ext_r[a][k] == '0) zero_any[a] = 1'b1;
    end
  end

  // odometer step per array
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic done;
      done = 1'b0;
      for (int k = 0; k < MAX_RANK; k++) begin
        cnt_nxt[a][k] = cnt_r[a][k];
        off_nxt[a][k] = off_r[a][k];
        if (!done && 32'(k) < 32'(rk[a])) begin
          if ({1'b0, cnt_r[a][k]} + 32'd1 < {1'b0, ext_r[a][k]}) begin
            cnt_nxt[a][k] = cnt_r[a][k] + 1'b1;
            off_nxt[a][k] = off_r[a][k] + AW'(signed'(str_r[a][k]));
            done = 1'b1;
          end else begin
            cnt_nxt[a][k] = '0;
            off_nxt[a][k] = '0;
          end
        end
      end
      carry[a] = !done;
    end
  end

  // current element address: offsets summed over the dimensions in use
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_c[a] = '0;
      for (int k = 0; k < MAX_RANK; k++)
        if (32'(k) < 32'(rk[a])) sum_c[a] = sum_c[a] + off_r[a][k];
    end
  end

  always_comb begin
    logic [1:0] ph;
    ph = ph_r; mv = 1'b0; fp = 1'b0; lst = 1'b0; stv = ST_OK; adv = 3'b000;
    if (q_data.cmd == CMD_MOVE) begin
      if (ph_r == PH_FIN || zero_any[1]) begin
        stv = ST_DONE;
      end else begin
        if (ph == PH_SOURCE && zero_any[0]) ph = PH_PAD;
        if (ph == PH_PAD && (rk[2] == 4'd0 || zero_any[2])) begin
          stv = ST_SHORT;
        end else begin
          mv = 1'b1;
          adv[1] = 1'b1;
          if (ph == PH_SOURCE) begin
            adv[0] = 1'b1;
            if (carry[0]) ph = PH_PAD;
          end else begin
            fp = 1'b1;
            adv[2] = 1'b1;
          end
          if (carry[1]) begin
            lst = 1'b1;
            ph = PH_FIN;
          end
        end
      end
    end
    ph_nxt = ph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_SOURCE;
      o_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < MAX_RANK; k++) begin
          ext_r[a][k] <= '0;
          str_r[a][k] <= '0;
          cnt_r[a][k] <= '0;
          off_r[a][k] <= '0;
        end
      end
    end else begin
      if (o_valid_r && out_ch.ready) o_valid_r <= 1'b0;
      if (step) begin
        o_valid_r <= 1'b1;
        if (restart) begin
          ph_r <= PH_SOURCE;
          for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < MAX_RANK; k++) begin
              cnt_r[a][k] <= '0;
              off_r[a][k] <= '0;
            end
          end
        end else if (q_data.cmd == CMD_LOAD) begin
          for (int a = 0; a < 3; a++)
            for (int k = 0; k < MAX_RANK; k++)
              if (q_data.sel == 2'(a) && q_data.dim == 3'(k)) begin
                ext_r[a][k] <= q_data.extent;
                str_r[a][k] <= q_data.stride;
              end
        end else if (q_data.cmd == CMD_MOVE) begin
          ph_r <= ph_nxt;
          for (int a = 0; a < 3; a++)
            if (adv[a]) begin
              for (int k = 0; k < MAX_RANK; k++) begin
                cnt_r[a][k] <= cnt_nxt[a][k];
                off_r[a][k] <= off_nxt[a][k];
              end
            end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ch.move_valid    <= mv;
      out_ch.from_pad      <= fp;
      out_ch.last_move     <= lst;
      out_ch.status        <= stv;
      out_ch.read_address  <= mv ? (fp ? sum_c[2] : sum_c[0]) : '0;
      out_ch.write_address <= mv ? sum_c[1] : '0;
    end
  end

  assign out_ch.valid = o_valid_r;
endmodule

/* rtl/core/strided_reshape_address_generator.sv */
// a word's result is registered in the output register as it leaves the queue;
// throughput: one word per cycle unless a full output register is held; a move sums
// offsets and steps odometers; a two-word queue ahead of them lets either side stall
// reset (rst_n low, synchronous): descriptors, counters and offsets cleared,
// ranks to source 1, result 1, pad 0, phase to source
module strided_reshape_address_generator
  import srag_pkg::*;
#(
  parameter int MAX_RANK  = 7,
  parameter int ADDR_BITS = 48
) (
  input logic         clk,
  input logic         rst_n,
  srag_in_if.sink     in_ch,
  srag_out_if.source  out_ch,
  srag_cfg_if.sink    cfg_ch
);
  logic [2:0] srank_r, rrank_r, prank_r;
  logic       f_valid, f_ready, b_valid, b_ready;
  srag_word_t f_data, b_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srank_r <= 3'd1;
      rrank_r <= 3'd1;
      prank_r <= 3'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SOURCE_RANK: srank_r <= cfg_ch.data;
        CFG_RESULT_RANK: rrank_r <= cfg_ch.data;
        CFG_PAD_RANK:    prank_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  srag_front #(.MAX_RANK(MAX_RANK)) u_front (
    .in_ch(in_ch), .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  srag_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  srag_back #(.MAX_RANK(MAX_RANK), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .srank(srank_r), .rrank(rrank_r), .prank(prank_r), .out_ch(out_ch)
  );
endmodule

/* rtl/core/srag_checker.sv */
// ----------------------------------------------------------------------------
// srag_checker
// port-level checks of the address generator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module srag_checker
  import srag_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       move_valid,
  input logic       from_pad,
  input logic       last_move,
  input logic [1:0] status
);
  `SRAG_ASSERT_IMP(a_move_ok, clk, rst_n, out_valid && move_valid, status == ST_OK, "bad status")
  `SRAG_ASSERT_IMP(a_nomove_flags, clk, rst_n, out_valid && !move_valid, !from_pad && !last_move, "flags")
  `SRAG_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status <= ST_SHORT, "bad status code")
  `SRAG_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "dropped")
endmodule

bind strided_reshape_address_generator srag_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .move_valid(out_ch.move_valid), .from_pad(out_ch.from_pad),
  .last_move(out_ch.last_move), .status(out_ch.status)
);

/* tb/srag_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srag testbench channel notes
// the channel interfaces come from the rtl; this file holds the shared
// testbench types used by the scoreboard and the driver
// ----------------------------------------------------------------------------
package srag_tb_pkg;
  import srag_pkg::*;

  typedef struct {
    logic        move_valid;
    logic [47:0] read_address;
    logic        from_pad;
    logic [47:0] write_address;
    logic        last_move;
    logic [1:0]  status;
  } move_word_t;

  class move_scoreboard;
    logic [2:0]  srank_q, rrank_q, prank_q;
    logic [30:0] ext [3][7];
    logic [31:0] strd [3][7];
    logic [30:0] cnt [3][7];
    logic [47:0] off [3][7];
    logic [1:0]  ph;
    move_word_t  pending[$];
    int          mismatches;

    function new();
      mismatches = 0;
      srank_q = 3'd1;
      rrank_q = 3'd1;
      prank_q = 3'd0;
      foreach (ext[a, k]) begin
        ext[a][k] = '0;
        strd[a][k] = '0;
      end
      clear_counters();
    endfunction

    function void clear_counters();
      foreach (cnt[a, k]) begin
        cnt[a][k] = '0;
        off[a][k] = '0;
      end
      ph = PH_SOURCE;
    endfunction

    function void set_rank(logic [1:0] idx, logic [2:0] v);
      if (idx == CFG_SOURCE_RANK) srank_q = v;
      else if (idx == CFG_RESULT_RANK) rrank_q = v;
      else if (idx == CFG_PAD_RANK) prank_q = v;
    endfunction

    function bit has_zero(int a, int rank);
      for (int k = 0; k < rank; k++)
        if (ext[a][k] == 0) return 1;
      return 0;
    endfunction

    function logic [47:0] offset_sum(int a, int rank);
      logic [47:0] s;
      s = '0;
      for (int k = 0; k < rank; k++) s += off[a][k];
      return s;
    endfunction

    // odometer step, 1 on carry out of the top rank
    function bit odometer_step(int a, int rank);
      for (int k = 0; k < rank; k++) begin
        if ({1'b0, cnt[a][k]} + 32'd1 < {1'b0, ext[a][k]}) begin
          cnt[a][k]++;
          off[a][k] = off[a][k] + {{16{strd[a][k][31]}}, strd[a][k]};
          return 0;
        end
        cnt[a][k] = '0;
        off[a][k] = '0;
      end
      return 1;
    endfunction

    function void note_input(logic [1:0] cmd, logic [1:0] sel, logic [2:0] dim,
                             logic [30:0] e, logic [31:0] s);
      move_word_t r;
      int sr, rr, pr;
      r = '{default: '0};
      sr = (srank_q == 3'd0) ? 1 : int'(srank_q);
      rr = (rrank_q == 3'd0) ? 1 : int'(rrank_q);
      pr = int'(prank_q);
      if (cmd == CMD_LOAD) begin
        if (dim < 7 && sel <= SEL_PAD) begin
          ext[sel][dim] = e;
          strd[sel][dim] = s;
        end
      end else if (cmd == CMD_RESTART) begin
        clear_counters();
      end else if (cmd == CMD_MOVE) begin
        if (ph == PH_FIN || has_zero(SEL_RESULT, rr)) begin
          r.status = ST_DONE;
        end else begin
          if (ph == PH_SOURCE && has_zero(SEL_SOURCE, sr)) ph = PH_PAD;
          if (ph == PH_PAD && (pr == 0 || has_zero(SEL_PAD, pr))) begin
            r.status = ST_SHORT;
          end else begin
            r.move_valid = 1;
            r.write_address = offset_sum(SEL_RESULT, rr);
            if (ph == PH_SOURCE) begin
              r.read_address = offset_sum(SEL_SOURCE, sr);
              if (odometer_step(SEL_SOURCE, sr)) ph = PH_PAD;
            end else begin
              r.from_pad = 1;
              r.read_address = offset_sum(SEL_PAD, pr);
              void'(odometer_step(SEL_PAD, pr));
            end
            if (odometer_step(SEL_RESULT, rr)) begin
              r.last_move = 1;
              ph = PH_FIN;
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(move_word_t got);
      move_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
        return;
      end
      exp_w = pending.pop_front();
      if (got.move_valid !== exp_w.move_valid || got.read_address !== exp_w.read_address ||
          got.from_pad !== exp_w.from_pad || got.write_address !== exp_w.write_address ||
          got.last_move !== exp_w.last_move || got.status !== exp_w.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: exp v%0b rd %h p%0b wr %h l%0b st%0d, got v%0b rd %h p%0b wr %h l%0b st%0d",
                   $realtime, exp_w.move_valid, exp_w.read_address, exp_w.from_pad,
                   exp_w.write_address, exp_w.last_move, exp_w.status,
                   got.move_valid, got.read_address, got.from_pad,
                   got.write_address, got.last_move, got.status);
      end
    endfunction
  endclass
endpackage

/* tb/tb_strided_reshape_address_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strided_reshape_address_generator
// drives descriptor loads, restarts, no-ops and moves with random idling on both
// sides and compares every output word with a predicted word
// ----------------------------------------------------------------------------
module tb_strided_reshape_address_generator;
  import srag_pkg::*;
  import srag_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   send_idle, recv_idle;

  srag_in_if  in_ch ();
  srag_out_if #(.ADDR_BITS(48)) out_ch ();
  srag_cfg_if cfg_ch ();

  strided_reshape_address_generator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  move_scoreboard sb;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver with random stall
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      move_word_t w;
      w.move_valid = out_ch.move_valid;
      w.read_address = out_ch.read_address;
      w.from_pad = out_ch.from_pad;
      w.write_address = out_ch.write_address;
      w.last_move = out_ch.last_move;
      w.status = out_ch.status;
      sb.check_result(w);
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // valid stays up across back-to-back words and drops only when idling
  task automatic send_word(logic [1:0] cmd, logic [1:0] sel, logic [2:0] dim,
                           logic [30:0] e, logic [31:0] s);
    cfg_ch.valid <= 0;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.array_select <= sel;
    in_ch.dim_index <= dim;
    in_ch.extent <= e;
    in_ch.stride <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, sel, dim, e, s);
  endtask

  task automatic write_rank(logic [1:0] idx, logic [2:0] v);
    in_ch.valid <= 0;
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_rank(idx, v);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // mostly small extents so that moves reach carries and the pad phase
  function automatic logic [30:0] pick_extent();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 31'd0;
    if (r < 90) return 31'($urandom_range(1, 4));
    if (r < 95) return 31'h7fffffff;
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] pick_stride();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h80000000;
    if (r == 1) return 32'h7fffffff;
    if (r < 6) return $urandom_range(0, 40) - 32'd20;
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    logic [2:0] sr, rr, pr;
    sr = 3'($urandom_range(7));
    rr = 3'($urandom_range(7));
    pr = 3'($urandom_range(7));
    if ($urandom_range(3) == 0) begin
      sr = 3'd1; rr = 3'd7; pr = 3'd0;
    end
    write_rank(CFG_SOURCE_RANK, sr);
    write_rank(CFG_RESULT_RANK, rr);
    write_rank(CFG_PAD_RANK, pr);
    for (int k = 0; k < 7; k++) begin
      send_word(CMD_LOAD, SEL_SOURCE, 3'(k), pick_extent(), pick_stride());
      send_word(CMD_LOAD, SEL_RESULT, 3'(k), pick_extent(), pick_stride());
      send_word(CMD_LOAD, SEL_PAD, 3'(k), pick_extent(), pick_stride());
    end
    send_word(CMD_RESTART, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 80)
        send_word(CMD_MOVE, 2'($urandom), 3'($urandom), 31'($urandom), $urandom);
      else if (r < 84)
        send_word(CMD_RESTART, 2'($urandom), 3'($urandom), 31'($urandom), $urandom);
      else if (r < 87)
        send_word(CMD_NOP, 2'($urandom), 3'($urandom), 31'($urandom), $urandom);
      else
        send_word(CMD_LOAD, 2'($urandom), 3'($urandom), pick_extent(), pick_stride());
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    send_idle = 0;
    recv_idle = 0;
    in_ch.valid = 0;
    in_ch.cmd = CMD_LOAD;
    in_ch.array_select = SEL_SOURCE;
    in_ch.dim_index = 3'd0;
    in_ch.extent = 31'd0;
    in_ch.stride = 32'd0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_SOURCE_RANK;
    cfg_ch.data = 3'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty shape, short source, extremes, pad wrap, odd codes
    send_word(CMD_MOVE, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    send_word(CMD_LOAD, SEL_RESULT, 3'd0, 31'd3, 32'h7fffffff);
    send_word(CMD_MOVE, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    send_word(CMD_LOAD, SEL_SOURCE, 3'd0, 31'd2, 32'h80000000);
    repeat (4) send_word(CMD_MOVE, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    drain();
    write_rank(CFG_PAD_RANK, 3'd1);
    send_word(CMD_LOAD, SEL_PAD, 3'd0, 31'h7fffffff, 32'hffffffff);
    send_word(CMD_LOAD, SEL_NONE, 3'd0, 31'd5, 32'd5);
    send_word(CMD_LOAD, SEL_SOURCE, 3'd7, 31'd5, 32'd5);
    send_word(CMD_NOP, SEL_NONE, 3'd7, 31'h7fffffff, 32'hffffffff);
    send_word(CMD_RESTART, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    repeat (4) send_word(CMD_MOVE, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    send_word(CMD_RESTART, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    send_word(CMD_LOAD, SEL_RESULT, 3'd0, 31'd1, 32'd0);
    send_word(CMD_MOVE, SEL_SOURCE, 3'd0, 31'd0, 32'd0);
    drain();

    send_idle = 19; recv_idle = 65;
    repeat (8) random_phase(50);
    send_idle = 65; recv_idle = 19;
    repeat (8) random_phase(50);
    send_idle = 0; recv_idle = 0;
    repeat (10) random_phase(50);
    write_rank(CFG_SOURCE_RANK, 3'd0);
    write_rank(CFG_RESULT_RANK, 3'd0);
    write_rank(CFG_PAD_RANK, 3'd7);
    random_phase(30);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
